FILE: design/i2cdw_pkg.sv
// Package for the I2C display write master.
// Holds field widths, sequence stage codes and protocol constants.
// No dependencies.
`timescale 1ns / 1ps

package i2cdw_pkg;

    localparam int AddrWidth = 7;
    localparam int ByteWidth = 8;

    localparam logic [AddrWidth-1:0] DefaultDeviceAddress = 7'h3c;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_COMMAND = 2'd1;
    localparam logic [1:0] CMD_DATA = 2'd2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_BYTES = 2'd2;
    localparam logic [1:0] ST_STOP = 2'd3;

    localparam logic [1:0] SLOT_ADDRESS = 2'd0;
    localparam logic [1:0] SLOT_CONTROL = 2'd1;
    localparam logic [1:0] SLOT_PAYLOAD = 2'd2;
    localparam logic [1:0] SLOT_ABORT = 2'd3;

    localparam logic [1:0] PHASE_DRIVE = 2'd0;
    localparam logic [1:0] PHASE_HIGH = 2'd1;
    localparam logic [1:0] PHASE_LOW = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic [ByteWidth-1:0] CTRL_COMMAND = 8'h00;
    localparam logic [ByteWidth-1:0] CTRL_DATA = 8'h40;

    localparam int InDataWidth = 16;
    localparam int InUserWidth = 2;
    localparam int OutDataWidth = 8;

endpackage

FILE: design/i2c_display_write_master.sv
// I2C display write master: top level and its bus phase sequencer.
// Depends on i2cdw_pkg.
`timescale 1ns / 1ps

// Each input word is one tick of the bus phase clock. A tick whose tuser
// carries a command or data request while the block is idle starts a write
// transaction: start, address byte, control byte, payload byte, stop.
// Every accepted word yields exactly one output word holding the line levels
// driven after that tick and the busy, nack and done flags.
// The configuration port writes the seven-bit device address; the user must write
// it only while no transaction is running, as the block itself does not enforce this.
// The next state and the output word are computed in one pass from the
// accepted word and stored together, so an output word appears in the cycle after
// its input word and one word is taken every cycle while the receiver does not stall.
// The output register holds its word while the receiver stalls; the input
// side then stays not ready until the held word is taken.
// Reset puts the bus at idle (SCL and SDA high), the address at 0x3c and
// leaves no output word pending.
module i2c_display_write_master
    import i2cdw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [AddrWidth-1:0]    cfg_wdata,         // device_address
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [InDataWidth-1:0]  s_axis_tdata,      // payload[7:0], sda_in[8], zeros
    input  logic [InUserWidth-1:0]  s_axis_tuser,      // command[1:0]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OutDataWidth-1:0] m_axis_tdata       // scl, sda_out, sda_release,
                                                       // busy_res, nack, done_res, zeros
);

    logic [AddrWidth-1:0] device_address_reg;
    logic [1:0]           stage_reg, stage_next;
    logic [1:0]           slot_reg, slot_next;
    logic [3:0]           bit_index_reg, bit_index_next;
    logic [1:0]           phase_reg, phase_next;
    logic [ByteWidth-1:0] shift_reg, shift_next;
    logic [ByteWidth-1:0] payload_hold_reg, payload_hold_next;
    logic                 is_data_reg, is_data_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 released_reg, released_next;
    logic                 out_valid_reg;
    logic [OutDataWidth-1:0] out_data_reg;

    logic [1:0]           command;
    logic [ByteWidth-1:0] payload;
    logic                 sda_in;
    logic                 busy, nack, done;
    logic                 accept;

    assign command = s_axis_tuser;
    assign payload = s_axis_tdata[ByteWidth-1:0];
    assign sda_in = s_axis_tdata[ByteWidth];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        stage_next = stage_reg;
        slot_next = slot_reg;
        bit_index_next = bit_index_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        payload_hold_next = payload_hold_reg;
        is_data_next = is_data_reg;
        scl_next = scl_reg;
        sda_next = sda_reg;
        released_next = released_reg;
        busy = 1'b0;
        nack = 1'b0;
        done = 1'b0;
        unique case (stage_reg)
            ST_IDLE:
            begin
                if (command == CMD_COMMAND || command == CMD_DATA)
                begin
                    payload_hold_next = payload;
                    is_data_next = (command == CMD_DATA);
                    sda_next = 1'b0;
                    scl_next = 1'b1;
                    stage_next = ST_START;
                    busy = 1'b1;
                end
            end
            ST_START:
            begin
                busy = 1'b1;
                scl_next = 1'b0;
                shift_next = {device_address_reg, 1'b0};
                slot_next = SLOT_ADDRESS;
                bit_index_next = '0;
                phase_next = PHASE_DRIVE;
                stage_next = ST_BYTES;
            end
            ST_BYTES:
            begin
                busy = 1'b1;
                if (bit_index_reg < BITS_PER_BYTE)
                begin
                    if (phase_reg == PHASE_DRIVE)
                    begin
                        sda_next = shift_reg[ByteWidth-1];
                        phase_next = PHASE_HIGH;
                    end
                    else if (phase_reg == PHASE_HIGH)
                    begin
                        scl_next = 1'b1;
                        phase_next = PHASE_LOW;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                        shift_next = {shift_reg[ByteWidth-2:0], 1'b0};
                        phase_next = PHASE_DRIVE;
                        bit_index_next = bit_index_reg + 4'd1;
                    end
                end
                else
                begin
                    if (phase_reg == PHASE_DRIVE)
                    begin
                        released_next = 1'b1;
                        phase_next = PHASE_HIGH;
                    end
                    else if (phase_reg == PHASE_HIGH)
                    begin
                        scl_next = 1'b1;
                        if (slot_reg == SLOT_ADDRESS && sda_in)
                        begin
                            nack = 1'b1;
                            slot_next = SLOT_ABORT;
                        end
                        phase_next = PHASE_LOW;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        released_next = 1'b0;
                        phase_next = PHASE_DRIVE;
                        bit_index_next = '0;
                        if (slot_reg == SLOT_PAYLOAD || slot_reg == SLOT_ABORT)
                        begin
                            stage_next = ST_STOP;
                        end
                        else if (slot_reg == SLOT_ADDRESS)
                        begin
                            slot_next = SLOT_CONTROL;
                            shift_next = is_data_reg ? CTRL_DATA : CTRL_COMMAND;
                        end
                        else
                        begin
                            slot_next = SLOT_PAYLOAD;
                            shift_next = payload_hold_reg;
                        end
                    end
                end
            end
            ST_STOP:
            begin
                busy = 1'b1;
                if (phase_reg == PHASE_DRIVE)
                begin
                    scl_next = 1'b1;
                    phase_next = PHASE_HIGH;
                end
                else
                begin
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                    done = 1'b1;
                    stage_next = ST_IDLE;
                    phase_next = PHASE_DRIVE;
                    slot_next = SLOT_ADDRESS;
                    bit_index_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DefaultDeviceAddress;
            stage_reg <= ST_IDLE;
            slot_reg <= SLOT_ADDRESS;
            bit_index_reg <= '0;
            phase_reg <= PHASE_DRIVE;
            shift_reg <= '0;
            payload_hold_reg <= '0;
            is_data_reg <= 1'b0;
            scl_reg <= 1'b1;
            sda_reg <= 1'b1;
            released_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                device_address_reg <= cfg_wdata;
            end
            if (accept)
            begin
                stage_reg <= stage_next;
                slot_reg <= slot_next;
                bit_index_reg <= bit_index_next;
                phase_reg <= phase_next;
                shift_reg <= shift_next;
                payload_hold_reg <= payload_hold_next;
                is_data_reg <= is_data_next;
                scl_reg <= scl_next;
                sda_reg <= sda_next;
                released_reg <= released_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {2'b00, done, nack, busy, released_next, sda_next, scl_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

endmodule

FILE: design/i2cdw_checker.sv
// Port-level checker for the I2C display write master, bound to the top level.
// Depends on i2cdw_pkg and i2c_display_write_master.
`timescale 1ns / 1ps

module i2cdw_checker
    import i2cdw_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [OutDataWidth-1:0] m_axis_tdata
);

    // A stalled output word stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled output word changed or was dropped.");

    // A nack only occurs inside a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3] && m_axis_tdata[0])
        else $error("Nack reported outside an acknowledge clock phase.");

    // A completed stop leaves both lines high.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[0] && m_axis_tdata[1]
            && !m_axis_tdata[2] && m_axis_tdata[3])
        else $error("Stop completed without the bus at idle levels.");

    // While SDA is released the held drive level is low and a transaction runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1] && m_axis_tdata[3])
        else $error("SDA released outside an acknowledge.");

endmodule

bind i2c_display_write_master i2cdw_checker u_i2cdw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/i2c_display_write_master_test.sv
// Self-checking testbench for the I2C display write master.
// Drives bus ticks and checks every output word against its predictor or a pinned word.
// Depends on i2cdw_pkg and i2c_display_write_master.
`timescale 1ns / 1ps

module i2c_display_write_master_test;
    import i2cdw_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int DirectedRows = 16;
    localparam int AddressAckTick = 27;
    localparam int DrainTicks = 90;
    localparam int PhaseWords = 60;
    localparam int AddressPhases = 6;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] payload;
        logic       sda;
        logic [7:0] count;
        logic       pinned;
        logic [7:0] word;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [AddrWidth-1:0]    cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [InDataWidth-1:0]  s_axis_tdata;
    logic [InUserWidth-1:0]  s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OutDataWidth-1:0] m_axis_tdata;

    logic       pinned_en;
    logic [7:0] pinned_word;

    logic [AddrWidth-1:0] pr_address;
    logic [1:0]           pr_stage;
    logic [1:0]           pr_slot;
    logic [3:0]           pr_bit;
    logic [1:0]           pr_phase;
    logic [7:0]           pr_shift;
    logic [7:0]           pr_payload;
    logic                 pr_is_data;
    logic                 pr_scl;
    logic                 pr_sda;
    logic                 pr_released;

    logic [7:0] expected_words[$];
    int         mismatch_count;
    int         words_sent;
    logic       sender_gaps_on;
    logic       receiver_stalls_on;
    logic       hold_off_req;
    stim_row_t  directed_rows [0:DirectedRows-1];

    i2c_display_write_master dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // Advances the bus model by one tick and returns the output word it drives.
    function automatic logic [7:0] bus_phase_step(input logic [1:0] cmd,
                                                  input logic [7:0] payload,
                                                  input logic sda_in);
        logic busy;
        logic nack;
        logic done;
        busy = 1'b1;
        nack = 1'b0;
        done = 1'b0;
        case (pr_stage)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (cmd == CMD_COMMAND || cmd == CMD_DATA)
                begin
                    pr_payload = payload;
                    pr_is_data = (cmd == CMD_DATA);
                    pr_sda = 1'b0;
                    pr_scl = 1'b1;
                    pr_stage = ST_START;
                    busy = 1'b1;
                end
            end
            ST_START:
            begin
                pr_scl = 1'b0;
                pr_shift = {pr_address, 1'b0};
                pr_slot = SLOT_ADDRESS;
                pr_bit = 4'd0;
                pr_phase = PHASE_DRIVE;
                pr_stage = ST_BYTES;
            end
            ST_BYTES:
            begin
                if (pr_bit < BITS_PER_BYTE)
                begin
                    if (pr_phase == PHASE_DRIVE)
                    begin
                        pr_sda = pr_shift[7];
                        pr_phase = PHASE_HIGH;
                    end
                    else if (pr_phase == PHASE_HIGH)
                    begin
                        pr_scl = 1'b1;
                        pr_phase = PHASE_LOW;
                    end
                    else
                    begin
                        pr_scl = 1'b0;
                        pr_sda = 1'b0;
                        pr_shift = {pr_shift[6:0], 1'b0};
                        pr_phase = PHASE_DRIVE;
                        pr_bit = pr_bit + 4'd1;
                    end
                end
                else if (pr_phase == PHASE_DRIVE)
                begin
                    pr_released = 1'b1;
                    pr_phase = PHASE_HIGH;
                end
                else if (pr_phase == PHASE_HIGH)
                begin
                    pr_scl = 1'b1;
                    // Only the address acknowledge can abort the transfer.
                    if (pr_slot == SLOT_ADDRESS && sda_in)
                    begin
                        nack = 1'b1;
                        pr_slot = SLOT_ABORT;
                    end
                    pr_phase = PHASE_LOW;
                end
                else
                begin
                    pr_scl = 1'b0;
                    pr_released = 1'b0;
                    pr_phase = PHASE_DRIVE;
                    pr_bit = 4'd0;
                    if (pr_slot == SLOT_PAYLOAD || pr_slot == SLOT_ABORT)
                    begin
                        pr_stage = ST_STOP;
                    end
                    else
                    begin
                        pr_slot = pr_slot + 2'd1;
                        if (pr_slot == SLOT_CONTROL)
                        begin
                            pr_shift = pr_is_data ? CTRL_DATA : CTRL_COMMAND;
                        end
                        else
                        begin
                            pr_shift = pr_payload;
                        end
                    end
                end
            end
            default:
            begin
                pr_scl = 1'b1;
                if (pr_phase == PHASE_DRIVE)
                begin
                    pr_phase = PHASE_HIGH;
                end
                else
                begin
                    pr_sda = 1'b1;
                    done = 1'b1;
                    pr_stage = ST_IDLE;
                    pr_phase = PHASE_DRIVE;
                    pr_slot = SLOT_ADDRESS;
                    pr_bit = 4'd0;
                end
            end
        endcase
        return {2'b00, done, nack, busy, pr_released, pr_sda, pr_scl};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_address = DefaultDeviceAddress;
            pr_stage = ST_IDLE;
            pr_slot = SLOT_ADDRESS;
            pr_bit = 4'd0;
            pr_phase = PHASE_DRIVE;
            pr_shift = 8'h00;
            pr_payload = 8'h00;
            pr_is_data = 1'b0;
            pr_scl = 1'b1;
            pr_sda = 1'b1;
            pr_released = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pr_address = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                logic [7:0] predicted;
                predicted = bus_phase_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
                expected_words.push_back(pinned_en ? pinned_word : predicted);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("unexpected output word %02h", m_axis_tdata);
                    end
                end
                else
                begin
                    logic [7:0] wanted;
                    wanted = expected_words.pop_front();
                    if (m_axis_tdata !== wanted)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display({"mismatch: scl/sda/release/busy/nack/done expected ",
                                      "%b/%b/%b/%b/%b/%b (%02h), got %b/%b/%b/%b/%b/%b (%02h)"},
                                     wanted[0], wanted[1], wanted[2], wanted[3], wanted[4],
                                     wanted[5], wanted, m_axis_tdata[0], m_axis_tdata[1],
                                     m_axis_tdata[2], m_axis_tdata[3], m_axis_tdata[4],
                                     m_axis_tdata[5], m_axis_tdata);
                        end
                    end
                end
            end
        end
    end

    // Offers one tick and returns at the clock edge that accepts it.
    task automatic offer_tick(input logic [1:0] cmd, input logic [7:0] payload,
                              input logic sda_in, input logic pin, input logic [7:0] word);
        int gap;
        if ($urandom_range(0, 39) == 0)
        begin
            sender_gaps_on = !sender_gaps_on;
        end
        gap = sender_gaps_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, sda_in, payload};
        s_axis_tuser <= cmd;
        pinned_en <= pin;
        pinned_word <= word;
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // Plain ticks bring any running transfer to its stop before the bus goes quiet.
    task automatic settle_bus();
        repeat (DrainTicks)
        begin
            offer_tick(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'b0, 8'h00);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random_transfer();
        logic       nack_at_address;
        logic [1:0] cmd;
        int         length;
        nack_at_address = ($urandom_range(0, 3) == 0);
        cmd = $urandom_range(0, 1) ? CMD_DATA : CMD_COMMAND;
        if ($urandom_range(0, 15) == 0)
        begin
            cmd = 2'($urandom_range(0, 3));
        end
        offer_tick(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 8'h00);
        length = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 84) : 84 + $urandom_range(0, 4);
        for (int k = 1; k <= length; k++)
        begin
            offer_tick(($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : CMD_TICK,
                       8'($urandom_range(0, 255)),
                       (k == AddressAckTick) ? nack_at_address : 1'($urandom_range(0, 1)),
                       1'b0, 8'h00);
        end
    endtask

    initial
    begin
        int limit;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                limit = 150;
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    receiver_stalls_on = !receiver_stalls_on;
                end
                limit = receiver_stalls_on ? $urandom_range(0, 11) : 0;
            end
            if (limit > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                for (int c = 1; c < limit; c++) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin
        #2000000;
        $display("i2c_display_write_master_test: errors");
        $finish;
    end

    initial
    begin
        logic [AddrWidth-1:0] address;
        int                   phase_end;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_TICK;
        pinned_en = 1'b0;
        pinned_word = 8'h00;
        mismatch_count = 0;
        words_sent = 0;
        sender_gaps_on = 1'b1;
        receiver_stalls_on = 1'b1;
        hold_off_req = 1'b0;

        // Runs at the reset address: idle ticks, a full command write, a late request
        // while busy, an address NACK abort, and requests around the stop.
        directed_rows = '{
            '{CMD_TICK,    8'h00, 1'b0, 8'd1,  1'b1, 8'h03},
            '{CMD_UNUSED,  8'hFF, 1'b1, 8'd1,  1'b1, 8'h03},
            '{CMD_COMMAND, 8'hFF, 1'b0, 8'd1,  1'b1, 8'h09},
            '{CMD_TICK,    8'h00, 1'b0, 8'd1,  1'b1, 8'h08},
            '{CMD_TICK,    8'h00, 1'b0, 8'd30, 1'b0, 8'h00},
            '{CMD_DATA,    8'h12, 1'b1, 8'd1,  1'b0, 8'h00},
            '{CMD_TICK,    8'hAA, 1'b1, 8'd56, 1'b0, 8'h00},
            '{CMD_DATA,    8'h00, 1'b0, 8'd1,  1'b1, 8'h09},
            '{CMD_TICK,    8'h00, 1'b1, 8'd32, 1'b0, 8'h00},
            '{CMD_COMMAND, 8'h01, 1'b0, 8'd1,  1'b1, 8'h09},
            '{CMD_TICK,    8'h00, 1'b0, 8'd82, 1'b0, 8'h00},
            '{CMD_DATA,    8'h80, 1'b0, 8'd1,  1'b0, 8'h00},
            '{CMD_DATA,    8'h80, 1'b0, 8'd1,  1'b0, 8'h00},
            '{CMD_DATA,    8'h80, 1'b0, 8'd1,  1'b1, 8'h09},
            '{CMD_TICK,    8'h00, 1'b0, 8'd90, 1'b0, 8'h00},
            '{CMD_UNUSED,  8'h5A, 1'b1, 8'd2,  1'b1, 8'h03}
        };

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DirectedRows; r++)
        begin
            repeat (directed_rows[r].count)
            begin
                offer_tick(directed_rows[r].cmd, directed_rows[r].payload, directed_rows[r].sda,
                           directed_rows[r].pinned, directed_rows[r].word);
            end
        end

        for (int p = 0; p < AddressPhases; p++)
        begin
            settle_bus();
            if (p == 0)
            begin
                address = 7'd0;
            end
            else if (p == 1)
            begin
                address = 7'd127;
            end
            else
            begin
                address = 7'($urandom_range(0, 127));
            end
            cfg_we <= 1'b1;
            cfg_wdata <= address;
            @(negedge clk);
            cfg_we <= 1'b0;
            if (p == 2)
            begin
                hold_off_req = 1'b1;
            end
            phase_end = words_sent + PhaseWords;
            while (words_sent < phase_end) run_random_transfer();
        end

        settle_bus();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
        begin
            $display("i2c_display_write_master_test: clean");
        end
        else
        begin
            $display("i2c_display_write_master_test: errors");
        end
        $finish;
    end

endmodule
